// File: design/mnva_pkg.sv
// shared types and codes for the midi note voice allocator
// no dependencies
package mnva_pkg;

    localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
    localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
    localparam int         STATUS_BIT      = 7;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_ON   = 2'd1;
    localparam logic [1:0] MODE_OFF  = 2'd2;

    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_STARTED   = 3'd1;
    localparam logic [2:0] EV_FREED     = 3'd2;
    localparam logic [2:0] EV_DROPPED   = 3'd3;
    localparam logic [2:0] EV_UNMATCHED = 3'd4;

    // search request into the voice table
    typedef struct packed {
        logic       go;
        logic       note_on;
        logic [6:0] note;
    } mnva_cmd_t;

    // search outcome, one-cycle done pulse
    typedef struct packed {
        logic       done;
        logic       found;
        logic [2:0] idx;
    } mnva_rsp_t;

endpackage

// File: design/mnva_voices.sv
// voice table with a one-voice-per-cycle search and update unit
// depends on mnva_pkg
module mnva_voices
    import mnva_pkg::*;
#(
    parameter int VOICE_COUNT = 6
) (
    input  logic       clk,
    input  logic       rst_n,
    input  mnva_cmd_t  cmd,
    output mnva_rsp_t  rsp,
    output logic [5:0] active_voices
);

    localparam int IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICE_COUNT - 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic                   state_reg, state_next;
    logic [IDX_W-1:0]       scan_reg, scan_next;
    logic                   on_reg, on_next;
    logic [6:0]             key_reg, key_next;
    logic [VOICE_COUNT-1:0] active_reg, active_next;
    logic [6:0]             note_mem [VOICE_COUNT];
    mnva_rsp_t              rsp_reg, rsp_next;

    logic                   cur_active;
    logic [6:0]             cur_note;
    logic                   hit;
    logic [IDX_W+2:0]       scan_ext;

    // the shared compare: one stored voice against the key each cycle
    assign cur_active = active_reg[scan_reg];
    assign cur_note   = note_mem[scan_reg];
    assign hit        = on_reg ? !cur_active : (cur_active && (cur_note == key_reg));
    assign scan_ext   = (IDX_W + 3)'(scan_reg);

    always_comb
    begin
        state_next  = state_reg;
        scan_next   = scan_reg;
        on_next     = on_reg;
        key_next    = key_reg;
        active_next = active_reg;
        rsp_next    = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.go)
                begin
                    state_next = S_SCAN;
                    scan_next  = '0;
                    on_next    = cmd.note_on;
                    key_next   = cmd.note;
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    active_next[scan_reg] = on_reg;
                    rsp_next.done  = 1'b1;
                    rsp_next.found = 1'b1;
                    rsp_next.idx   = scan_ext[2:0];
                    state_next     = S_IDLE;
                end
                else if (scan_reg == LAST_IDX)
                begin
                    rsp_next.done = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            active_reg <= '0;
            rsp_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            rsp_reg    <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        on_reg   <= on_next;
        key_reg  <= key_next;
        if (state_reg == S_SCAN && hit && on_reg)
        begin
            note_mem[scan_reg] <= key_reg;
        end
    end

    assign rsp = rsp_reg;

    // only the first six voices are visible
    for (genvar g = 0; g < 6; g++)
    begin : g_mask
        if (g < VOICE_COUNT)
        begin : g_on
            assign active_voices[g] = active_reg[g];
        end
        else
        begin : g_off
            assign active_voices[g] = 1'b0;
        end
    end

endmodule

// File: design/midi_note_voice_allocator.sv
// top level of the midi note voice allocator: byte decode, running mode, result strobe
// depends on mnva_pkg and mnva_voices
//
// one received midi byte is taken per beat (start high while busy is low) and
// exactly one result follows, shown on the result ports for one cycle under
// valid; the receiver cannot stall, so results must be captured when valid is
// high. a status byte or an ignored data byte gives its result the cycle after
// the beat. the first data byte after a note-on or note-off status starts a
// voice search that checks one voice per clock in a shared compare unit;
// busy is high while the search runs. active_voices shows the first six
// voices and is current whenever valid is high. no clearing pass is needed
// after reset.
module midi_note_voice_allocator
    import mnva_pkg::*;
#(
    parameter int VOICE_COUNT = 6
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] midi_byte,
    output logic       valid,
    output logic [2:0] event_kind,
    output logic [2:0] voice_index,
    output logic [6:0] note_number,
    output logic [5:0] active_voices
);

    localparam logic T_IDLE = 1'b0;
    localparam logic T_WAIT = 1'b1;

    logic       state_reg, state_next;
    logic [1:0] mode_reg, mode_next;
    logic       pend_reg, pend_next;
    logic       valid_reg, valid_next;
    logic [2:0] kind_reg, kind_next;
    logic [2:0] vidx_reg, vidx_next;
    logic [6:0] note_reg, note_next;
    logic [6:0] key_reg, key_next;

    logic       accept;
    mnva_cmd_t  cmd;
    mnva_rsp_t  rsp;

    assign accept = start && (state_reg == T_IDLE);

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        pend_next  = pend_reg;
        valid_next = 1'b0;
        kind_next  = kind_reg;
        vidx_next  = vidx_reg;
        note_next  = note_reg;
        key_next   = key_reg;
        cmd        = '0;

        if (accept)
        begin
            if (midi_byte[STATUS_BIT])
            begin
                // status byte: pick the running mode, arm the first data byte
                priority if (midi_byte == STATUS_NOTE_ON)
                begin
                    mode_next = MODE_ON;
                    pend_next = 1'b1;
                end
                else if (midi_byte == STATUS_NOTE_OFF)
                begin
                    mode_next = MODE_OFF;
                    pend_next = 1'b1;
                end
                else
                begin
                    mode_next = MODE_NONE;
                    pend_next = 1'b0;
                end
                valid_next = 1'b1;
                kind_next  = EV_NONE;
                vidx_next  = '0;
                note_next  = '0;
            end
            else if (pend_reg && mode_reg != MODE_NONE)
            begin
                // first data byte: hand the note to the voice search
                cmd.go      = 1'b1;
                cmd.note_on = (mode_reg == MODE_ON);
                cmd.note    = midi_byte[6:0];
                key_next    = midi_byte[6:0];
                pend_next   = 1'b0;
                state_next  = T_WAIT;
            end
            else
            begin
                // velocity and other data bytes are ignored
                pend_next  = 1'b0;
                valid_next = 1'b1;
                kind_next  = EV_NONE;
                vidx_next  = '0;
                note_next  = '0;
            end
        end
        else if (state_reg == T_WAIT && rsp.done)
        begin
            valid_next = 1'b1;
            note_next  = key_reg;
            vidx_next  = rsp.found ? rsp.idx : 3'd0;
            if (mode_reg == MODE_ON)
            begin
                kind_next = rsp.found ? EV_STARTED : EV_DROPPED;
            end
            else
            begin
                kind_next = rsp.found ? EV_FREED : EV_UNMATCHED;
            end
            state_next = T_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            mode_reg  <= MODE_NONE;
            pend_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            pend_reg  <= pend_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        vidx_reg <= vidx_next;
        note_reg <= note_next;
        key_reg  <= key_next;
    end

    mnva_voices #(
        .VOICE_COUNT (VOICE_COUNT)
    ) u_voices (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .rsp           (rsp),
        .active_voices (active_voices)
    );

    assign busy        = (state_reg == T_WAIT);
    assign valid       = valid_reg;
    assign event_kind  = kind_reg;
    assign voice_index = vidx_reg;
    assign note_number = note_reg;

    // a result never shows while a search is still running
    a_strobe_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> !busy)
        else $error("result strobe while busy");

    // the voice unit only answers a search that is waiting for it
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> state_reg == T_WAIT)
        else $error("voice search done with nothing pending");

    // a started search holds the block busy the next cycle
    a_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.go |=> busy)
        else $error("search issued but block not busy");

    // a no-event result carries no voice and no note
    a_none_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && event_kind == EV_NONE) |-> (voice_index == 3'd0 && note_number == 7'd0))
        else $error("no-event result with voice or note set");

endmodule

// File: tb/mnva_event_checker.sv
// result checker for the midi note voice allocator: predicts one event per accepted beat
// and compares every strobed result against the oldest prediction
// depends on mnva_pkg
module mnva_event_checker
    import mnva_pkg::*;
#(
    parameter int VOICE_COUNT = 6
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic [7:0] midi_byte,
    input  logic       valid,
    input  logic [2:0] event_kind,
    input  logic [2:0] voice_index,
    input  logic [6:0] note_number,
    input  logic [5:0] active_voices,
    output int         fail_count,
    output int         pending,
    output int         n_checked,
    output int         n_started,
    output int         n_freed,
    output int         n_dropped,
    output int         n_unmatched
);

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] idx;
        logic [6:0] note;
        logic [5:0] mask;
    } voice_event_t;

    voice_event_t expected_events[$];
    voice_event_t oldest;

    logic [1:0] note_mode;
    logic       first_pending;
    logic       voice_on   [VOICE_COUNT];
    logic [6:0] voice_held [VOICE_COUNT];

    int fails;
    int checked;
    int kind_count [5];

    // one byte through the voice table, state updated in place
    function voice_event_t predict_event(input logic [7:0] b);
        voice_event_t ev;
        logic         hit;
        int           k;
        ev  = '0;
        hit = 1'b0;
        if (b[STATUS_BIT]) begin
            if (b == STATUS_NOTE_ON) begin
                note_mode     = MODE_ON;
                first_pending = 1'b1;
            end else if (b == STATUS_NOTE_OFF) begin
                note_mode     = MODE_OFF;
                first_pending = 1'b1;
            end else begin
                note_mode     = MODE_NONE;
                first_pending = 1'b0;
            end
        end else if (first_pending && note_mode != MODE_NONE) begin
            ev.note = b[6:0];
            if (note_mode == MODE_ON) begin
                ev.kind = EV_DROPPED;
                for (k = 0; k < VOICE_COUNT; k++) begin
                    if (!hit && !voice_on[k]) begin
                        voice_on[k]   = 1'b1;
                        voice_held[k] = b[6:0];
                        ev.kind       = EV_STARTED;
                        ev.idx        = k[2:0];
                        hit           = 1'b1;
                    end
                end
            end else begin
                ev.kind = EV_UNMATCHED;
                for (k = 0; k < VOICE_COUNT; k++) begin
                    if (!hit && voice_on[k] && voice_held[k] == b[6:0]) begin
                        voice_on[k] = 1'b0;
                        ev.kind     = EV_FREED;
                        ev.idx      = k[2:0];
                        hit         = 1'b1;
                    end
                end
            end
            first_pending = 1'b0;
        end else begin
            first_pending = 1'b0;
        end
        for (k = 0; k < VOICE_COUNT && k < 6; k++)
            ev.mask[k] = voice_on[k];
        return ev;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            note_mode     = MODE_NONE;
            first_pending = 1'b0;
            for (int k = 0; k < VOICE_COUNT; k++) begin
                voice_on[k]   = 1'b0;
                voice_held[k] = '0;
            end
            expected_events.delete();
            fails   = 0;
            checked = 0;
            for (int k = 0; k < 5; k++)
                kind_count[k] = 0;
            fail_count  <= 0;
            pending     <= 0;
            n_checked   <= 0;
            n_started   <= 0;
            n_freed     <= 0;
            n_dropped   <= 0;
            n_unmatched <= 0;
        end else begin
            // a result never lands on the edge of its own beat, so compare first
            if (valid) begin
                if (expected_events.size() == 0) begin
                    $error("result with no byte outstanding: event_kind %0d", event_kind);
                    fails++;
                end else begin
                    oldest = expected_events.pop_front();
                    check_field("event_kind", oldest.kind, event_kind);
                    check_field("voice_index", oldest.idx, voice_index);
                    check_field("note_number", oldest.note, note_number);
                    check_field("active_voices", oldest.mask, active_voices);
                    checked++;
                    if (oldest.kind <= EV_UNMATCHED)
                        kind_count[oldest.kind]++;
                end
            end
            if (start && !busy)
                expected_events.push_back(predict_event(midi_byte));
            fail_count  <= fails;
            pending     <= expected_events.size();
            n_checked   <= checked;
            n_started   <= kind_count[EV_STARTED];
            n_freed     <= kind_count[EV_FREED];
            n_dropped   <= kind_count[EV_DROPPED];
            n_unmatched <= kind_count[EV_UNMATCHED];
        end
    end

endmodule

// File: tb/tb_midi_note_voice_allocator.sv
// testbench top for the midi note voice allocator: clock, reset, byte stimulus and verdict
// depends on mnva_pkg, midi_note_voice_allocator and mnva_event_checker
module tb_midi_note_voice_allocator;
    import mnva_pkg::*;

    localparam int VOICE_COUNT = 6;

    // a status byte that is neither note on nor note off, clears the note mode
    localparam logic [7:0] TIMING_CLOCK = 8'hF8;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [7:0] midi_byte;
    logic       valid;
    logic [2:0] event_kind;
    logic [2:0] voice_index;
    logic [6:0] note_number;
    logic [5:0] active_voices;

    int fail_count;
    int pending;
    int n_checked;
    int n_started;
    int n_freed;
    int n_dropped;
    int n_unmatched;

    // chance in percent that the sender leaves a cycle empty before a beat
    int idle_pct;
    // beats sent so far, every byte counts
    int beats_counted;
    int beat_target;
    int drain_cycles;

    // small note set per phase so that note-off finds held voices often
    logic [6:0] note_pool      [0:7];
    logic [7:0] directed_bytes [0:23];
    int         phase_idle     [0:3];

    midi_note_voice_allocator #(
        .VOICE_COUNT(VOICE_COUNT)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .midi_byte    (midi_byte),
        .valid        (valid),
        .event_kind   (event_kind),
        .voice_index  (voice_index),
        .note_number  (note_number),
        .active_voices(active_voices)
    );

    // prediction and comparison live in the checker, the top only drives bytes
    mnva_event_checker #(
        .VOICE_COUNT(VOICE_COUNT)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .midi_byte    (midi_byte),
        .valid        (valid),
        .event_kind   (event_kind),
        .voice_index  (voice_index),
        .note_number  (note_number),
        .active_voices(active_voices),
        .fail_count   (fail_count),
        .pending      (pending),
        .n_checked    (n_checked),
        .n_started    (n_started),
        .n_freed      (n_freed),
        .n_dropped    (n_dropped),
        .n_unmatched  (n_unmatched)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // hard stop, far beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("tb_midi_note_voice_allocator: FAIL");
        $finish;
    end

    // one beat: optional idle cycles, then hold start until the block takes it
    // called at a falling edge with nothing yet driven in that step; returns
    // at the falling edge after the beat, again with nothing driven
    task automatic send_beat(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            start     <= 1'b0;
            midi_byte <= 8'($urandom_range(255));
            @(negedge clk);
        end
        start     <= 1'b1;
        midi_byte <= b;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        beats_counted++;
    endtask

    // one random phrase: mostly well-formed note messages, the rest noise
    task automatic send_phrase();
        logic [7:0] status;
        logic [6:0] note;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 72)
        begin
            // note status, note, usually velocity, now and then a running-status note
            status = ($urandom_range(99) < 55) ? STATUS_NOTE_ON : STATUS_NOTE_OFF;
            note   = ($urandom_range(99) < 85) ? note_pool[$urandom_range(7)]
                                               : 7'($urandom_range(127));
            send_beat(status);
            send_beat({1'b0, note});
            if ($urandom_range(99) < 80)
                send_beat(8'($urandom_range(127)));
            if ($urandom_range(99) < 10)
                send_beat({1'b0, note_pool[$urandom_range(7)]});
        end
        else if (pick < 80)
        begin
            // broken message: note status cut off by another status byte
            send_beat(($urandom_range(1) != 0) ? STATUS_NOTE_ON : STATUS_NOTE_OFF);
            send_beat(8'($urandom_range(255, 128)));
            send_beat({1'b0, note_pool[$urandom_range(7)]});
        end
        else if (pick < 90)
        begin
            send_beat(8'($urandom_range(255, 128)));
        end
        else
        begin
            status = 8'($urandom_range(255));
            send_beat(status);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        midi_byte     = 8'h00;
        idle_pct      = 0;
        beats_counted = 0;
        phase_idle    = '{0, 80, 23, 0};

        // directed: data with no mode, a velocity byte ignored,
        // the lowest free voice taken, all voices full then a drop, note-off
        // freeing the lowest holder of a note twice held, an unmatched note-off,
        // and a foreign status clearing the mode
        directed_bytes = '{
            8'h45,
            STATUS_NOTE_ON, 8'h00, 8'h40,
            STATUS_NOTE_ON, 8'h7F,
            STATUS_NOTE_ON, 8'h2A,
            STATUS_NOTE_ON, 8'h55,
            STATUS_NOTE_ON, 8'h2A,
            STATUS_NOTE_ON, 8'h01,
            STATUS_NOTE_ON, 8'h66,
            STATUS_NOTE_OFF, 8'h2A,
            STATUS_NOTE_OFF, 8'h2A,
            STATUS_NOTE_OFF, 8'h2A,
            TIMING_CLOCK, 8'h2A
        };

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_bytes[i])
            send_beat(directed_bytes[i]);

        // random phases at different sender idle levels
        beat_target = beats_counted;
        foreach (phase_idle[p])
        begin
            idle_pct = phase_idle[p];
            foreach (note_pool[i])
                note_pool[i] = 7'($urandom_range(127));
            note_pool[0] = (p % 2 == 0) ? 7'h00 : 7'h7F;
            beat_target += 281;
            while (beats_counted < beat_target)
                send_phrase();
        end

        start <= 1'b0;

        // drain: every beat owes exactly one result
        drain_cycles = 0;
        while (pending != 0 && drain_cycles < 1000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (VOICE_COUNT + 4) @(posedge clk);

        $display("checked %0d results over idle levels 0, 80, 23 and 0 percent",
                 n_checked);
        $display("voices started %0d, freed %0d, starts dropped %0d, offs unmatched %0d",
                 n_started, n_freed, n_dropped, n_unmatched);
        if (fail_count == 0 && pending == 0)
            $display("tb_midi_note_voice_allocator: PASS");
        else
            $display("tb_midi_note_voice_allocator: FAIL");
        $finish;
    end

endmodule
